@@ hdl/julia_set_escape_time_assert.svh @@
// Assertion macros for the escape-time engine.
// Each macro takes a label, the clock, the active-low reset, a condition and
// what must hold, and a message string.
`ifndef JULIA_SET_ESCAPE_TIME_ASSERT_SVH
`define JULIA_SET_ESCAPE_TIME_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define JSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define JSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define JSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hdl/jse_pkg.sv @@
`default_nettype none

package jse_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned MAX_ROUNDS_DEF = 255;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam int unsigned FRAC_BITS   = 28;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned STEP_W      = 31;
  localparam int unsigned INTENSITY_W = 8;
  localparam int unsigned APB_ADDR_W  = 5;

  // Narrowest origin register that still holds its reset value.
  localparam int unsigned ORIGIN_MIN_W = 9;

  // 4.0 in Q8.56.
  localparam logic [63:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

  localparam logic signed [31:0] SEED_RE_RST   = -32'sd195124484;
  localparam logic signed [31:0] SEED_IM_RST   = 32'sd50704005;
  localparam logic signed [31:0] CENTER_RE_RST = 32'sd0;
  localparam logic signed [31:0] CENTER_IM_RST = 32'sd0;
  localparam logic [30:0]        STEP_X_RST    = 31'd838861;
  localparam logic [30:0]        STEP_Y_RST    = 31'd1118481;
  localparam int unsigned        ORIGIN_COL_RST = 320;
  localparam int unsigned        ORIGIN_ROW_RST = 240;

  typedef enum logic [2:0] {
    REG_SEED_RE    = 3'd0,
    REG_SEED_IM    = 3'd1,
    REG_CENTER_RE  = 3'd2,
    REG_CENTER_IM  = 3'd3,
    REG_STEP_X     = 3'd4,
    REG_STEP_Y     = 3'd5,
    REG_ORIGIN_COL = 3'd6,
    REG_ORIGIN_ROW = 3'd7
  } reg_idx_e;

  // Complex point in signed Q4.28.
  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } point_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/jse_front.sv @@
`default_nettype none

module jse_front #(
  parameter int unsigned COORD_BITS = jse_pkg::COORD_BITS_DEF,
  parameter int unsigned ORIGIN_W   = jse_pkg::ORIGIN_MIN_W
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  pix_valid_i,
  output logic                       pix_ready_o,
  input  wire logic [COORD_BITS-1:0] pix_row_i,
  input  wire logic [COORD_BITS-1:0] pix_col_i,
  input  wire logic signed [31:0]    center_re_i,
  input  wire logic signed [31:0]    center_im_i,
  input  wire logic [30:0]           step_x_i,
  input  wire logic [30:0]           step_y_i,
  input  wire logic [ORIGIN_W-1:0]   origin_col_i,
  input  wire logic [ORIGIN_W-1:0]   origin_row_i,
  output logic                       push_o,
  output jse_pkg::point_t            push_data_o,
  input  wire jse_pkg::q_status_t    q_status_i
);

  localparam int unsigned DW = ORIGIN_W + 1;
  localparam int unsigned PW = DW + 32;
  localparam int unsigned SW = PW + 1;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_SUM
  } state_e;

  state_e               state_q;
  logic signed [DW-1:0] dcol_q, drow_q;
  logic signed [PW-1:0] prod_re_q, prod_im_q;
  logic signed [DW-1:0] dcol_d, drow_d;
  logic signed [SW-1:0] sum_re, sum_im;

  always_comb begin
    dcol_d = $signed(DW'(pix_col_i)) - $signed(DW'(origin_col_i));
    drow_d = $signed(DW'(origin_row_i)) - $signed(DW'(pix_row_i));
    sum_re = SW'(prod_re_q) + SW'(center_re_i);
    sum_im = SW'(prod_im_q) + SW'(center_im_i);
  end

  assign pix_ready_o    = (state_q == F_IDLE);
  assign push_o         = (state_q == F_SUM) && !q_status_i.full;
  assign push_data_o.re = jse_pkg::sat32(64'(sum_re));
  assign push_data_o.im = jse_pkg::sat32(64'(sum_im));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      dcol_q    <= '0;
      drow_q    <= '0;
      prod_re_q <= '0;
      prod_im_q <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (pix_valid_i) begin
            dcol_q  <= dcol_d;
            drow_q  <= drow_d;
            state_q <= F_MUL;
          end
        end
        F_MUL: begin
          prod_re_q <= dcol_q * $signed({1'b0, step_x_i});
          prod_im_q <= drow_q * $signed({1'b0, step_y_i});
          state_q   <= F_SUM;
        end
        F_SUM: begin
          if (!q_status_i.full) begin
            state_q <= F_IDLE;
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/jse_queue.sv @@
`default_nettype none

module jse_queue #(
  parameter int unsigned WIDTH = $bits(jse_pkg::point_t),
  parameter int unsigned DEPTH = jse_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic [WIDTH-1:0]   push_data_i,
  input  wire logic               pop_i,
  output logic [WIDTH-1:0]        pop_data_o,
  output jse_pkg::q_status_t      status_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    if (p == AW'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign pop_data_o     = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == CW'(DEPTH));
  assign status_o.empty = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/jse_engine.sv @@
`default_nettype none

module jse_engine #(
  parameter int unsigned MAX_ROUNDS = jse_pkg::MAX_ROUNDS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic signed [31:0]                  seed_re_i,
  input  wire logic signed [31:0]                  seed_im_i,
  output logic                                     pop_o,
  input  wire jse_pkg::point_t                     pop_data_i,
  input  wire jse_pkg::q_status_t                  q_status_i,
  output logic                                     res_valid_o,
  input  wire logic                                res_ready_i,
  output logic [jse_pkg::INTENSITY_W-1:0]          res_data_o
);

  localparam int unsigned CW = $clog2(MAX_ROUNDS + 1);
  localparam int unsigned NW = 34;

  typedef enum logic [1:0] {
    E_IDLE,
    E_MUL,
    E_STEP,
    E_DONE
  } state_e;

  state_e             state_q;
  logic signed [31:0] re_q, im_q;
  logic [63:0]        rr_q, ii_q;
  logic signed [63:0] ri_q;
  logic [CW-1:0]      cnt_q;
  logic               res_valid_q;
  logic [jse_pkg::INTENSITY_W-1:0] res_data_q;

  logic               escaped;
  logic signed [63:0] diff_sq;
  logic signed [63:0] diff_sh, ri_sh;
  logic signed [NW-1:0] nre, nim;
  logic [CW-1:0]      cnt_inc;
  logic               slot_free;
  logic [jse_pkg::INTENSITY_W-1:0] intensity;

  always_comb begin
    escaped   = (64'(rr_q + ii_q) > jse_pkg::ESCAPE_LIMIT);
    diff_sq   = $signed(rr_q) - $signed(ii_q);
    diff_sh   = diff_sq >>> jse_pkg::FRAC_BITS;
    // Twice the cross product shifted by the fraction is one bit less of shift.
    ri_sh     = ri_q >>> (jse_pkg::FRAC_BITS - 1);
    nre       = NW'(diff_sh) + NW'(seed_re_i);
    nim       = NW'(ri_sh) + NW'(seed_im_i);
    cnt_inc   = cnt_q + 1'b1;
    slot_free = !res_valid_q || res_ready_i;
    intensity = (32'(cnt_q) > 32'd255) ? 8'hFF : 8'(cnt_q);
  end

  assign pop_o       = (state_q == E_IDLE) && !q_status_i.empty;
  assign res_valid_o = res_valid_q;
  assign res_data_o  = res_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= E_IDLE;
      re_q        <= '0;
      im_q        <= '0;
      rr_q        <= '0;
      ii_q        <= '0;
      ri_q        <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      res_data_q  <= '0;
    end else begin
      // In the done state the valid flag is set below instead.
      if (res_valid_q && res_ready_i && (state_q != E_DONE)) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        E_IDLE: begin
          if (!q_status_i.empty) begin
            re_q    <= pop_data_i.re;
            im_q    <= pop_data_i.im;
            cnt_q   <= '0;
            state_q <= E_MUL;
          end
        end
        E_MUL: begin
          rr_q    <= re_q * re_q;
          ii_q    <= im_q * im_q;
          ri_q    <= re_q * im_q;
          state_q <= E_STEP;
        end
        E_STEP: begin
          if (escaped) begin
            state_q <= E_DONE;
          end else begin
            re_q  <= jse_pkg::sat32(64'(nre));
            im_q  <= jse_pkg::sat32(64'(nim));
            cnt_q <= cnt_inc;
            if (cnt_inc == CW'(MAX_ROUNDS)) begin
              state_q <= E_DONE;
            end else begin
              state_q <= E_MUL;
            end
          end
        end
        E_DONE: begin
          if (slot_free) begin
            res_valid_q <= 1'b1;
            res_data_q  <= intensity;
            state_q     <= E_IDLE;
          end
        end
        default: begin
          state_q <= E_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/julia_set_escape_time.sv @@
// Julia-set escape-time engine. Each input item is one pixel (row, column);
// each result item is that pixel's escape count, the number of z = z^2 + seed
// rounds done before |z| exceeds 2, with the round limit MAX_ROUNDS meaning the
// point never escaped (counts above 255 read as 255). All arithmetic is signed
// Q4.28 fixed point, and the starting point is saturated to that range. A
// front stage maps the pixel to its starting point in registered steps
// (origin offset, step multiply, center add) and places it in a two-entry
// queue; a round unit behind the queue works on one pixel at a time, while
// the front maps the next pixel, waiting while the queue is full. Each
// round goes through the three 32x32 multipliers and then the escape
// compare and seed add, so the round unit sets the throughput. A
// finished count waits in an output register while the next pixel is worked
// on. Configuration registers sit at byte offsets 0x00 seed_re, 0x04 seed_im,
// 0x08 center_re, 0x0C center_im, 0x10 step_x, 0x14 step_y, 0x18 origin_col,
// 0x1C origin_row, and should be written only while no pixel is in flight.
`default_nettype none

`include "julia_set_escape_time_assert.svh"

module julia_set_escape_time #(
  parameter int unsigned COORD_BITS = jse_pkg::COORD_BITS_DEF,
  parameter int unsigned MAX_ROUNDS = jse_pkg::MAX_ROUNDS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // Pixel input.
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // Fields from bit 0 up: pixel_row, pixel_col, zero padding.
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // Result output.
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // Fields from bit 0 up: intensity.
  output logic [jse_pkg::INTENSITY_W-1:0]            m_axis_tdata,
  // Register port.
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [jse_pkg::APB_ADDR_W-1:0]        paddr,
  input  wire logic [31:0]                           pwdata,
  output logic [31:0]                                prdata,
  output logic                                       pready
);

  localparam int unsigned ORIGIN_W =
    (COORD_BITS > jse_pkg::ORIGIN_MIN_W) ? COORD_BITS : jse_pkg::ORIGIN_MIN_W;

  // Configuration registers.
  logic signed [31:0]  seed_re_q, seed_im_q, center_re_q, center_im_q;
  logic [30:0]         step_x_q, step_y_q;
  logic [ORIGIN_W-1:0] origin_col_q, origin_row_q;

  logic             reg_wr;
  jse_pkg::reg_idx_e reg_idx;

  // Front-to-back queue.
  logic               q_push, q_pop;
  jse_pkg::point_t    q_wdata, q_rdata;
  jse_pkg::q_status_t q_status;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite;
  assign reg_idx = jse_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_re_q    <= jse_pkg::SEED_RE_RST;
      seed_im_q    <= jse_pkg::SEED_IM_RST;
      center_re_q  <= jse_pkg::CENTER_RE_RST;
      center_im_q  <= jse_pkg::CENTER_IM_RST;
      step_x_q     <= jse_pkg::STEP_X_RST;
      step_y_q     <= jse_pkg::STEP_Y_RST;
      origin_col_q <= ORIGIN_W'(jse_pkg::ORIGIN_COL_RST);
      origin_row_q <= ORIGIN_W'(jse_pkg::ORIGIN_ROW_RST);
    end else if (reg_wr) begin
      case (reg_idx)
        jse_pkg::REG_SEED_RE:    seed_re_q    <= pwdata;
        jse_pkg::REG_SEED_IM:    seed_im_q    <= pwdata;
        jse_pkg::REG_CENTER_RE:  center_re_q  <= pwdata;
        jse_pkg::REG_CENTER_IM:  center_im_q  <= pwdata;
        jse_pkg::REG_STEP_X:     step_x_q     <= pwdata[30:0];
        jse_pkg::REG_STEP_Y:     step_y_q     <= pwdata[30:0];
        jse_pkg::REG_ORIGIN_COL: origin_col_q <= ORIGIN_W'(pwdata[COORD_BITS-1:0]);
        jse_pkg::REG_ORIGIN_ROW: origin_row_q <= ORIGIN_W'(pwdata[COORD_BITS-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      jse_pkg::REG_SEED_RE:    prdata = seed_re_q;
      jse_pkg::REG_SEED_IM:    prdata = seed_im_q;
      jse_pkg::REG_CENTER_RE:  prdata = center_re_q;
      jse_pkg::REG_CENTER_IM:  prdata = center_im_q;
      jse_pkg::REG_STEP_X:     prdata = {1'b0, step_x_q};
      jse_pkg::REG_STEP_Y:     prdata = {1'b0, step_y_q};
      jse_pkg::REG_ORIGIN_COL: prdata = 32'(origin_col_q);
      jse_pkg::REG_ORIGIN_ROW: prdata = 32'(origin_row_q);
      default:                 prdata = '0;
    endcase
  end

  // The front maps a pixel to its starting point.
  jse_front #(
    .COORD_BITS (COORD_BITS),
    .ORIGIN_W   (ORIGIN_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_valid_i  (s_axis_tvalid),
    .pix_ready_o  (s_axis_tready),
    .pix_row_i    (s_axis_tdata[COORD_BITS-1:0]),
    .pix_col_i    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .center_re_i  (center_re_q),
    .center_im_i  (center_im_q),
    .step_x_i     (step_x_q),
    .step_y_i     (step_y_q),
    .origin_col_i (origin_col_q),
    .origin_row_i (origin_row_q),
    .push_o       (q_push),
    .push_data_o  (q_wdata),
    .q_status_i   (q_status)
  );

  jse_queue #(
    .WIDTH ($bits(jse_pkg::point_t)),
    .DEPTH (jse_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .status_o    (q_status)
  );

  // The round unit iterates one starting point until escape or the limit.
  jse_engine #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_re_i   (seed_re_q),
    .seed_im_i   (seed_im_q),
    .pop_o       (q_pop),
    .pop_data_i  (q_rdata),
    .q_status_i  (q_status),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_o  (m_axis_tdata)
  );

  // The front never writes a full queue, and the round unit never reads an empty one.
  `JSE_ASSERT_IMPL(a_push_room, clk_i, rst_ni, q_push, !q_status.full, "queue written while full")
  `JSE_ASSERT_IMPL(a_pop_item, clk_i, rst_ni, q_pop, !q_status.empty, "queue read while empty")
  // A lone write leaves at least one starting point waiting.
  `JSE_ASSERT_NEXT(a_push_fills, clk_i, rst_ni, q_push && !q_pop, !q_status.empty, "queue lost an entry")
  // No count can exceed the round limit.
  `JSE_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, m_axis_tvalid, 32'(m_axis_tdata) <= 32'(MAX_ROUNDS), "count above round limit")

endmodule

`default_nettype wire

@@ verif/tb_julia_set_escape_time.sv @@
`timescale 1ns / 1ps

module tb_julia_set_escape_time;

  localparam int unsigned COORD_W     = jse_pkg::COORD_BITS_DEF;
  localparam int unsigned ROUND_LIMIT = jse_pkg::MAX_ROUNDS_DEF;
  localparam int unsigned PIX_W       = ((2 * COORD_W + 7) / 8) * 8;
  // The slowest correct run is roughly 515 pixels that never escape, each
  // holding the round unit for the full round limit plus the longest gap
  // and stall on either side. The limit is about five times that.
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  // One pixel in flight and the escape count it must produce.
  typedef struct {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [7:0]         count;
  } pixel_count_t;

  // Mirror of the register file, plus the counts still owed by the block.
  class escape_scoreboard;
    logic signed [31:0]  seed_re, seed_im, center_re, center_im;
    logic [30:0]         step_x, step_y;
    logic [COORD_W-1:0]  origin_col, origin_row;
    pixel_count_t        owed_counts[$];
    int unsigned         errors;
    int unsigned         consumed;

    function new();
      seed_re    = jse_pkg::SEED_RE_RST;
      seed_im    = jse_pkg::SEED_IM_RST;
      center_re  = jse_pkg::CENTER_RE_RST;
      center_im  = jse_pkg::CENTER_IM_RST;
      step_x     = jse_pkg::STEP_X_RST;
      step_y     = jse_pkg::STEP_Y_RST;
      origin_col = COORD_W'(jse_pkg::ORIGIN_COL_RST);
      origin_row = COORD_W'(jse_pkg::ORIGIN_ROW_RST);
      errors     = 0;
      consumed   = 0;
    endfunction

    // Bits above a register's width are dropped, as the block does.
    function void write_reg(jse_pkg::reg_idx_e idx, logic [31:0] value);
      case (idx)
        jse_pkg::REG_SEED_RE:    seed_re = value;
        jse_pkg::REG_SEED_IM:    seed_im = value;
        jse_pkg::REG_CENTER_RE:  center_re = value;
        jse_pkg::REG_CENTER_IM:  center_im = value;
        jse_pkg::REG_STEP_X:     step_x = value[30:0];
        jse_pkg::REG_STEP_Y:     step_y = value[30:0];
        jse_pkg::REG_ORIGIN_COL: origin_col = value[COORD_W-1:0];
        jse_pkg::REG_ORIGIN_ROW: origin_row = value[COORD_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Escape count of one pixel. Squares are exact Q8.56 values; the
    // arithmetic shift back to Q4.28 rounds toward minus infinity.
    function logic [7:0] escape_count(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
      longint      re, im, rr, ii, next_re, next_im;
      logic [63:0] mag2;
      int unsigned rounds;
      re = clamp32((longint'(col) - longint'(origin_col)) * longint'(step_x)
                   + longint'(center_re));
      im = clamp32((longint'(origin_row) - longint'(row)) * longint'(step_y)
                   + longint'(center_im));
      rounds = 0;
      while (rounds < ROUND_LIMIT) begin
        rr   = re * re;
        ii   = im * im;
        mag2 = rr + ii;
        if (mag2 > jse_pkg::ESCAPE_LIMIT) break;
        next_re = ((rr - ii) >>> jse_pkg::FRAC_BITS) + longint'(seed_re);
        next_im = ((2 * re * im) >>> jse_pkg::FRAC_BITS) + longint'(seed_im);
        re = clamp32(next_re);
        im = clamp32(next_im);
        rounds++;
      end
      return (rounds > 255) ? 8'd255 : 8'(rounds);
    endfunction

    function void note_pixel(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
      pixel_count_t entry;
      entry.row   = row;
      entry.col   = col;
      entry.count = escape_count(row, col);
      owed_counts.push_back(entry);
    endfunction

    function void check_count(logic [7:0] got);
      pixel_count_t head;
      if (owed_counts.size() == 0) begin
        $display("%0t: intensity with no pixel pending: expected none, actual %0d",
                 $time, got);
        errors++;
        return;
      end
      head = owed_counts.pop_front();
      consumed++;
      if (head.count !== got) begin
        $display("%0t: intensity mismatch at row %0d col %0d: expected %0d, actual %0d",
                 $time, head.row, head.col, head.count, got);
        errors++;
      end
    endfunction

    function void close_out();
      foreach (owed_counts[i]) begin
        $display("%0t: no intensity for row %0d col %0d: expected %0d, actual none",
                 $time, owed_counts[i].row, owed_counts[i].col, owed_counts[i].count);
        errors++;
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  // Fields from bit 0 up: pixel_row, pixel_col.
  logic [PIX_W-1:0]                s_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  // Fields from bit 0 up: intensity.
  logic [jse_pkg::INTENSITY_W-1:0] m_axis_tdata;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [jse_pkg::APB_ADDR_W-1:0]  paddr;
  logic [31:0]                     pwdata;
  logic [31:0]                     prdata;
  logic                            pready;

  escape_scoreboard sb = new();

  int unsigned pixels_sent = 0;
  int unsigned cycle_count = 0;
  // Set for the last stretch of the run: no gaps from the sender and no
  // stalls from the receiver.
  bit          tail_no_idle = 1'b0;

  julia_set_escape_time uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Both handshakes are sampled at the rising edge, before any of this
  // edge's updates land. The result is checked before the new pixel is noted;
  // a result leaving in the same cycle always belongs to an older pixel.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_count(m_axis_tdata);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_pixel(s_axis_tdata[COORD_W-1:0], s_axis_tdata[2*COORD_W-1:COORD_W]);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: stalls in random bursts, separated by ready stretches of
  // varied length, some of them long enough to span many pixels.
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (!tail_no_idle && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(200, 1500)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  // One register write: setup cycle, then access cycle. The select stays
  // high afterwards so that writes can follow back to back; set_view drops
  // it at the end of a burst.
  task automatic apb_write(input jse_pkg::reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, value);
  endtask

  task automatic set_view(input logic [31:0] seed_re, input logic [31:0] seed_im,
                          input logic [31:0] center_re, input logic [31:0] center_im,
                          input logic [31:0] step_x, input logic [31:0] step_y,
                          input logic [31:0] origin_col, input logic [31:0] origin_row);
    apb_write(jse_pkg::REG_SEED_RE, seed_re);
    apb_write(jse_pkg::REG_SEED_IM, seed_im);
    apb_write(jse_pkg::REG_CENTER_RE, center_re);
    apb_write(jse_pkg::REG_CENTER_IM, center_im);
    apb_write(jse_pkg::REG_STEP_X, step_x);
    apb_write(jse_pkg::REG_STEP_Y, step_y);
    apb_write(jse_pkg::REG_ORIGIN_COL, origin_col);
    apb_write(jse_pkg::REG_ORIGIN_ROW, origin_row);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drive one pixel and hold it until the block takes it. Valid is left high
  // so that the next pixel can follow without a bubble.
  task automatic feed_pixel(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
    if (!tail_no_idle && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tdata  <= PIX_W'({col, row});
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixels_sent++;
  endtask

  // Stop sending and wait for every pixel sent so far to return its count.
  task automatic wait_all_counts();
    s_axis_tvalid <= 1'b0;
    while (sb.consumed < pixels_sent) @(posedge clk_i);
  endtask

  // Pixel offset that keeps the start point within about two units of the
  // view center for the given step.
  function automatic int reach(logic [30:0] step);
    int q;
    if (step == 0) return 2047;
    q = 536870912 / int'(step);
    if (q < 1) return 1;
    if (q > 2047) return 2047;
    return q;
  endfunction

  // Most pixels land in the interesting region around the view center, where
  // orbits run long; the rest are spread over the whole coordinate range.
  task automatic pick_pixel(output logic [COORD_W-1:0] row, output logic [COORD_W-1:0] col);
    int span_c;
    int span_r;
    if ($urandom_range(0, 9) < 2) begin
      row = COORD_W'($urandom);
      col = COORD_W'($urandom);
    end else begin
      span_c = reach(sb.step_x);
      span_r = reach(sb.step_y);
      col = COORD_W'(int'(sb.origin_col) + int'($urandom_range(0, 2 * span_c)) - span_c);
      row = COORD_W'(int'(sb.origin_row) + int'($urandom_range(0, 2 * span_r)) - span_r);
    end
  endtask

  // One view per phase, the reset view first. Known Julia constants give long
  // orbits; the step register's ignored top bit is also set at random.
  task automatic choose_view(input int phase);
    logic [31:0] sr, si, cr, ci, sx, sy;
    sx = {$urandom_range(0, 1) == 1, 31'($urandom_range(1 << 15, 1 << 21))};
    sy = {$urandom_range(0, 1) == 1, 31'($urandom_range(1 << 15, 1 << 21))};
    cr = 32'($urandom_range(0, 1 << 28)) - 32'(1 << 27);
    ci = 32'($urandom_range(0, 1 << 28)) - 32'(1 << 27);
    case (phase)
      1: begin sr = -32'sd214748365; si = 32'sd41875931;  end
      2: begin sr = 32'sd76504268;   si = 32'sd2684355;   end
      3: begin sr = -32'sd33017561;  si = 32'sd199984414; end
      4: begin sr = 32'sd0;          si = 32'sd268435456; end
      6: begin
        sr = $urandom;
        si = $urandom;
        sr = {{3{sr[31]}}, sr[31:3]};
        si = {{3{si[31]}}, si[31:3]};
      end
      7: begin sr = -32'sd107374182; si = 32'sd161061274; end
      default: begin sr = jse_pkg::SEED_RE_RST; si = jse_pkg::SEED_IM_RST; end
    endcase
    if (phase == 0) begin
      set_view(jse_pkg::SEED_RE_RST, jse_pkg::SEED_IM_RST,
               jse_pkg::CENTER_RE_RST, jse_pkg::CENTER_IM_RST,
               {1'b0, jse_pkg::STEP_X_RST}, {1'b0, jse_pkg::STEP_Y_RST},
               jse_pkg::ORIGIN_COL_RST, jse_pkg::ORIGIN_ROW_RST);
    end else if (phase == 5) begin
      // Every register takes a fully random word.
      set_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom);
    end else begin
      set_view(sr, si, cr, ci, sx, sy, $urandom, $urandom);
    end
  endtask

  initial begin
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset view: the center pixel, the four corners, all but (0, 0) escaping
    // at once, alternating bit patterns, and a few pixels near the center.
    feed_pixel(12'd240, 12'd320);
    feed_pixel(12'd0, 12'd0);
    feed_pixel(12'hFFF, 12'hFFF);
    feed_pixel(12'd0, 12'hFFF);
    feed_pixel(12'hFFF, 12'd0);
    feed_pixel(12'hAAA, 12'h555);
    feed_pixel(12'h555, 12'hAAA);
    feed_pixel(12'd250, 12'd300);
    feed_pixel(12'd230, 12'd345);

    // Zero seed and zero start: the orbit stays at the origin and never
    // escapes, so the pixel runs the full round limit.
    wait_all_counts();
    set_view('0, '0, '0, '0, '0, '0, '0, '0);
    feed_pixel(12'd0, 12'd0);
    feed_pixel(12'hFFF, 12'hFFF);

    // Largest steps and offsets: every start coordinate saturates, in both
    // directions. The all-ones words also check that upper bits are dropped.
    wait_all_counts();
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    feed_pixel(12'd0, 12'd0);
    feed_pixel(12'hFFF, 12'hFFF);
    feed_pixel(12'hFFF, 12'd0);
    feed_pixel(12'd0, 12'hFFF);

    // Escape boundary on the real axis: exactly |z| = 2 does not escape,
    // one step beyond it does.
    wait_all_counts();
    set_view('0, '0, 32'h2000_0000, '0, 32'd1, 32'd1, '0, '0);
    feed_pixel(12'd0, 12'd0);
    feed_pixel(12'd0, 12'd1);

    // The same boundary on the imaginary axis at z = -2i.
    wait_all_counts();
    set_view('0, '0, '0, 32'hE000_0000, 32'd1, 32'd1, '0, '0);
    feed_pixel(12'd0, 12'd0);
    feed_pixel(12'd1, 12'd0);

    // Random part: eight views, about sixty pixels each. Halfway through one
    // view the sender holds off until every count has come back.
    for (int phase = 0; phase < 8; phase++) begin
      wait_all_counts();
      choose_view(phase);
      if (phase == 7) tail_no_idle = 1'b1;
      for (int k = 0; k < 62; k++) begin
        if (phase == 3 && k == 31) wait_all_counts();
        pick_pixel(row, col);
        feed_pixel(row, col);
      end
    end

    wait_all_counts();
    // Watch a while longer for any result the block should not produce.
    repeat (2 * ROUND_LIMIT + 16) @(posedge clk_i);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
